@@ sv/bads_pkg.sv @@
package bads_pkg;

	// Image size limits
	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;

	// Field and register widths
	localparam int CFG_W  = 10;
	localparam int PIX_W  = 8;
	localparam int AVG_W  = 8;
	localparam int OCOL_W = 9;
	localparam int OROW_W = 9;
	localparam int SUM_W  = 26;
	localparam int IDX_W  = 2;

	// Derived widths
	localparam int COL_W  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CMP_W  = CFG_W + 2;
	localparam int FF_W   = 2 * CFG_W;
	localparam int DSH_W  = FF_W + AVG_W - 1;
	localparam int STEP_W = $clog2(AVG_W);

	typedef logic [IDX_W-1:0] cfg_idx_t;

	// Register indexes
	localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
	localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;
	localparam cfg_idx_t REG_FACTOR       = 2'd2;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = CFG_W'(512);
	localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = CFG_W'(512);
	localparam logic [CFG_W-1:0] RST_FACTOR       = CFG_W'(2);

	// Divider status seen by the top level
	typedef struct packed {
		logic busy;
		logic res_valid;
	} div_stat_t;

endpackage

@@ sv/bads_if.sv @@
interface bads_pixel_if import bads_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface bads_result_if import bads_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [AVG_W-1:0]  average;
	logic [OCOL_W-1:0] out_column;
	logic [OROW_W-1:0] out_row;
	logic              frame_done;

	modport source (output valid, output average, output out_column, output out_row,
		output frame_done, input ready);
	modport sink (input valid, input average, input out_column, input out_row,
		input frame_done, output ready);
endinterface

@@ sv/block_average_downscaler_unit.sv @@
// Channel | Dir | Payload                                   | Transfer when
// pix     | in  | pixel[7:0]                                | pix.valid & pix.ready
// res     | out | average[7:0] out_column out_row frame_done | res.valid & res.ready
// cfg     | in  | cfg_index, cfg_data[9:0]                  | cfg_we
//
// A pixel that does not finish a block does not hold off the input; pixels stream back to back.
// A pixel that finishes a block holds the input off while its sum is updated in
// the column RAM, divided in the bit-serial divider and loaded into the output
// register.
// Column sums live in a 512 x 26 RAM and are overwritten at each band start, so
// reset needs no clearing pass. A stalled output only stalls the input once the
// next finished block needs the divider.
module block_average_downscaler_unit import bads_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	bads_pixel_if.sink       pix,
	bads_result_if.source    res
);

	// Configuration
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [CFG_W-1:0] factor_q;
	logic [FF_W-1:0]  ff_q;
	logic             cfg_hit;
	logic [CFG_W-1:0] w_eff;
	logic [CFG_W-1:0] h_eff;
	logic [CFG_W-1:0] f_eff;
	logic [CMP_W-1:0] f_ext;

	// Position counters
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] cib_q;
	logic [ROW_W-1:0] rib_q;
	logic [COL_W-1:0] blk_col_q;
	logic [ROW_W-1:0] blk_row_q;
	logic [COL_W-1:0] bcs_q;
	logic [ROW_W-1:0] brs_q;

	logic col_end;
	logic row_end;
	logic cib_end;
	logic rib_end;
	logic col_fit;
	logic row_fit;
	logic col_last;
	logic row_last;
	logic in_blk;
	logic acc;

	// Stage 1
	logic             s1_valid;
	logic             s1_first;
	logic             s1_last;
	logic             s1_done;
	logic [PIX_W-1:0] s1_px;
	logic [COL_W-1:0] s1_idx;
	logic [ROW_W-1:0] s1_row;
	logic [SUM_W-1:0] s1_base;
	logic [SUM_W-1:0] s1_sum;
	logic [SUM_W-1:0] ram_rdata;
	logic             fwd_hit_q;
	logic [SUM_W-1:0] fwd_sum_q;

	// Divider and output
	div_stat_t        dstat;
	logic [AVG_W-1:0] quotient;
	logic             div_start;
	logic             res_take;
	logic [COL_W-1:0] tag_col_q;
	logic [ROW_W-1:0] tag_row_q;
	logic             tag_done_q;
	logic             out_valid_q;
	logic [AVG_W-1:0] out_avg_q;
	logic [OCOL_W-1:0] out_col_q;
	logic [OROW_W-1:0] out_row_q;
	logic             out_done_q;

	// Register file
	assign cfg_hit = cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
		cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_FACTOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			factor_q <= RST_FACTOR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				REG_FACTOR:       factor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective sizes: zero acts as one, sizes clamp to the maximum
	always_comb begin
		w_eff = width_q;
		if (width_q == '0) begin
			w_eff = CFG_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = CFG_W'(MAX_WIDTH);
		end
		h_eff = height_q;
		if (height_q == '0) begin
			h_eff = CFG_W'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_eff = CFG_W'(MAX_HEIGHT);
		end
		f_eff = (factor_q == '0) ? CFG_W'(1) : factor_q;
	end

	assign f_ext = CMP_W'(f_eff);

	// Block area n*n, refreshed every cycle from the factor register
	always_ff @(posedge clk) begin
		ff_q <= FF_W'(f_eff) * FF_W'(f_eff);
	end

	// Position decode
	assign col_end  = CMP_W'(in_col_q) + CMP_W'(1) >= CMP_W'(w_eff);
	assign row_end  = CMP_W'(in_row_q) + CMP_W'(1) >= CMP_W'(h_eff);
	assign cib_end  = CMP_W'(cib_q) + CMP_W'(1) >= f_ext;
	assign rib_end  = CMP_W'(rib_q) + CMP_W'(1) >= f_ext;
	assign col_fit  = CMP_W'(bcs_q) + f_ext <= CMP_W'(w_eff);
	assign row_fit  = CMP_W'(brs_q) + f_ext <= CMP_W'(h_eff);
	assign col_last = CMP_W'(bcs_q) + (f_ext << 1) > CMP_W'(w_eff);
	assign row_last = CMP_W'(brs_q) + (f_ext << 1) > CMP_W'(h_eff);
	assign in_blk   = col_fit && row_fit;

	// Input handshake: hold off while a finished block is in stage 1 or the divider is busy
	assign pix.ready = !(dstat.busy || (s1_valid && s1_last));
	assign acc       = pix.valid && pix.ready;

	// Raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			cib_q     <= '0;
			rib_q     <= '0;
			blk_col_q <= '0;
			blk_row_q <= '0;
			bcs_q     <= '0;
			brs_q     <= '0;
		end else if (cfg_hit) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			cib_q     <= '0;
			rib_q     <= '0;
			blk_col_q <= '0;
			blk_row_q <= '0;
			bcs_q     <= '0;
			brs_q     <= '0;
		end else if (acc) begin
			if (col_end) begin
				in_col_q  <= '0;
				cib_q     <= '0;
				blk_col_q <= '0;
				bcs_q     <= '0;
				if (row_end) begin
					in_row_q  <= '0;
					rib_q     <= '0;
					blk_row_q <= '0;
					brs_q     <= '0;
				end else begin
					in_row_q <= in_row_q + 1'b1;
					if (rib_end) begin
						rib_q     <= '0;
						blk_row_q <= blk_row_q + 1'b1;
						brs_q     <= brs_q + ROW_W'(f_eff);
					end else begin
						rib_q <= rib_q + 1'b1;
					end
				end
			end else begin
				in_col_q <= in_col_q + 1'b1;
				if (cib_end) begin
					cib_q     <= '0;
					blk_col_q <= blk_col_q + 1'b1;
					bcs_q     <= bcs_q + COL_W'(f_eff);
				end else begin
					cib_q <= cib_q + 1'b1;
				end
			end
		end
	end

	// Column sum store
	bads_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_WIDTH)
	) u_sums (
		.clk   (clk),
		.we    (s1_valid),
		.waddr (s1_idx),
		.wdata (s1_sum),
		.re    (acc),
		.raddr (blk_col_q),
		.rdata (ram_rdata)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid  <= 1'b0;
			s1_last   <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			s1_valid  <= acc && in_blk;
			s1_last   <= acc && in_blk && cib_end && rib_end;
			fwd_hit_q <= s1_valid && acc && (blk_col_q == s1_idx);
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (acc) begin
			s1_px    <= pix.pixel;
			s1_idx   <= blk_col_q;
			s1_row   <= blk_row_q;
			s1_first <= (cib_q == '0) && (rib_q == '0);
			s1_done  <= col_last && row_last;
		end
		fwd_sum_q <= s1_sum;
	end

	// Read-modify-write; forward the sum written on the edge of the read
	assign s1_base = fwd_hit_q ? fwd_sum_q : ram_rdata;
	assign s1_sum  = s1_first ? SUM_W'(s1_px) : s1_base + SUM_W'(s1_px);

	// Block average
	assign div_start = s1_valid && s1_last;

	bads_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (s1_sum),
		.divisor  (ff_q),
		.take     (res_take),
		.stat     (dstat),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (div_start) begin
			tag_col_q  <= s1_idx;
			tag_row_q  <= s1_row;
			tag_done_q <= s1_done;
		end
	end

	// Output register
	assign res_take = dstat.res_valid && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_avg_q  <= quotient;
			out_col_q  <= OCOL_W'(tag_col_q);
			out_row_q  <= OROW_W'(tag_row_q);
			out_done_q <= tag_done_q;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.average    = out_avg_q;
	assign res.out_column = out_col_q;
	assign res.out_row    = out_row_q;
	assign res.frame_done = out_done_q;

endmodule

@@ sv/bads_ram.sv @@
module bads_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port (old data on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/bads_div.sv @@
module bads_div import bads_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [FF_W-1:0]  divisor,
	input  logic             take,
	output div_stat_t        stat,
	output logic [AVG_W-1:0] quotient
);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  rem_q;
	logic [DSH_W-1:0]  dsh_q;
	logic [AVG_W-1:0]  quo_q;
	logic              fits;

	// Trial compare of remainder against the shifted divisor
	assign fits = DSH_W'(rem_q) >= dsh_q;

	// Step sequencing: one quotient bit per cycle, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(AVG_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (take) begin
				done_q <= 1'b0;
			end
		end
	end

	// Restoring division datapath; the quotient is known to fit in AVG_W bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= DSH_W'(divisor) << (AVG_W - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= rem_q - SUM_W'(dsh_q);
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[AVG_W-2:0], fits};
		end
	end

	assign stat.busy      = run_q | done_q;
	assign stat.res_valid = done_q;
	assign quotient       = quo_q;

endmodule

@@ sv/bads_checker.sv @@
module bads_checker import bads_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [AVG_W-1:0]  out_average,
	input logic [OCOL_W-1:0] out_column,
	input logic [OROW_W-1:0] out_row,
	input logic              out_done
);

	logic in_xfer;

	assign in_xfer = in_valid && in_ready;

	// A stalled result holds its value and payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_average) &&
		$stable(out_column) && $stable(out_row) && $stable(out_done))
		else $error("result changed while stalled");

	// No result is shown once reset has been seen at an edge
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid during reset");

	// A new result is loaded only while the divider blocks the input
	a_load_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_xfer))
		else $error("pixel taken while a result was being loaded");

endmodule

bind block_average_downscaler_unit bads_checker u_bads_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pix.valid),
	.in_ready    (pix.ready),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.out_average (res.average),
	.out_column  (res.out_column),
	.out_row     (res.out_row),
	.out_done    (res.frame_done)
);
